@@ sv/edd_pkg.sv @@
// ----------------------------------------------------------------------------
// Error diffusion dither package
// Shared types, kernel tap tables and reciprocal constants.
// ----------------------------------------------------------------------------
`default_nettype none

package edd_pkg;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned NUM_KERN   = 6;
  localparam int unsigned MAX_TAPS   = 12;
  localparam int unsigned ERR_W      = 18;
  localparam int unsigned RECIP_W    = 23;
  localparam int unsigned RECIP_SH   = 26;

  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_METHOD    = 2'd1;
  localparam logic [1:0] REG_WIDTH     = 2'd2;
  localparam logic [1:0] REG_HEIGHT    = 2'd3;

  localparam logic [2:0] METH_FIRST = 3'd1;
  localparam logic [2:0] METH_LAST  = 3'd6;

  // luma divide by 100: ceil(2^22 / 100)
  localparam logic [15:0] LUMA_RECIP = 16'd41944;
  localparam int unsigned LUMA_SH    = 22;

  typedef struct packed {
    logic [7:0] thr;
    logic [2:0] meth;
  } mode_t;

  typedef struct packed {
    logic [1:0] dy;
    logic [2:0] dx;
    logic [5:0] wt;
  } tap_t;

  localparam tap_t TZ = '{2'd0, 3'd0, 6'd0};

  // ceil(2^26 / divisor) per kernel
  localparam logic [RECIP_W-1:0] RECIP [NUM_KERN] = '{
    23'd4194304, 23'd1398102, 23'd1597831, 23'd2097152, 23'd2097152, 23'd335545
  };

  localparam logic [3:0] TAP_CNT [NUM_KERN] = '{4'd4, 4'd12, 4'd12, 4'd7, 4'd10, 4'd12};

  localparam tap_t KTAPS [NUM_KERN][MAX_TAPS] = '{
    '{'{2'd0,3'd4,6'd7}, '{2'd1,3'd2,6'd3}, '{2'd1,3'd3,6'd5}, '{2'd1,3'd4,6'd1},
      TZ, TZ, TZ, TZ, TZ, TZ, TZ, TZ},
    '{'{2'd0,3'd4,6'd7}, '{2'd0,3'd5,6'd5}, '{2'd1,3'd1,6'd3}, '{2'd1,3'd2,6'd5},
      '{2'd1,3'd3,6'd7}, '{2'd1,3'd4,6'd5}, '{2'd1,3'd5,6'd3}, '{2'd2,3'd1,6'd1},
      '{2'd2,3'd2,6'd3}, '{2'd2,3'd3,6'd5}, '{2'd2,3'd4,6'd3}, '{2'd2,3'd5,6'd1}},
    '{'{2'd0,3'd4,6'd8}, '{2'd0,3'd5,6'd4}, '{2'd1,3'd1,6'd2}, '{2'd1,3'd2,6'd4},
      '{2'd1,3'd3,6'd8}, '{2'd1,3'd4,6'd4}, '{2'd1,3'd5,6'd2}, '{2'd2,3'd1,6'd1},
      '{2'd2,3'd2,6'd2}, '{2'd2,3'd3,6'd4}, '{2'd2,3'd4,6'd2}, '{2'd2,3'd5,6'd1}},
    '{'{2'd0,3'd4,6'd8}, '{2'd0,3'd5,6'd4}, '{2'd1,3'd1,6'd2}, '{2'd1,3'd2,6'd4},
      '{2'd1,3'd3,6'd8}, '{2'd1,3'd4,6'd4}, '{2'd1,3'd5,6'd2}, TZ, TZ, TZ, TZ, TZ},
    '{'{2'd0,3'd4,6'd5}, '{2'd0,3'd5,6'd3}, '{2'd1,3'd1,6'd2}, '{2'd1,3'd2,6'd4},
      '{2'd1,3'd3,6'd5}, '{2'd1,3'd4,6'd4}, '{2'd1,3'd5,6'd2}, '{2'd2,3'd2,6'd2},
      '{2'd2,3'd3,6'd3}, '{2'd2,3'd4,6'd2}, TZ, TZ},
    '{'{2'd0,3'd5,6'd32}, '{2'd1,3'd0,6'd12}, '{2'd1,3'd2,6'd26}, '{2'd1,3'd4,6'd30},
      '{2'd1,3'd6,6'd16}, '{2'd2,3'd1,6'd12}, '{2'd2,3'd3,6'd26}, '{2'd2,3'd5,6'd12},
      '{2'd3,3'd0,6'd5}, '{2'd3,3'd2,6'd12}, '{2'd3,3'd4,6'd12}, '{2'd3,3'd6,6'd5}}
  };

endpackage

`default_nettype wire

@@ sv/error_diffusion_dither_core.sv @@
// ----------------------------------------------------------------------------
// Error diffusion dither core
// RGB stream in, one quantised bit per pixel out, six diffusion kernels.
// ----------------------------------------------------------------------------
// The back end works on one pixel at a time; with error spread it then
//   visits each kernel tap in turn, since the error store has one
//   read and one write port.
// Reset, and any write of width or height, runs a clearing pass over all
//   4 * 2**ceil(log2(MAX_WIDTH)) error store entries (4096 by default) with no pixel taken.
`default_nettype none

module error_diffusion_dither_core #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // red [7:0], green [15:8], blue [23:16]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [7:0]  m_axis_tdata,   // pixel_on, zero fill
  output logic             m_axis_tlast,   // frame_end
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [10:0] cfg_wdata_i
);

  localparam int unsigned WW = $clog2(MAX_WIDTH+1);
  localparam int unsigned HW = $clog2(MAX_HEIGHT+1);
  localparam int unsigned QC = $clog2(edd_pkg::FIFO_DEPTH+1);

  logic [7:0]     thr_q;
  logic [2:0]     meth_q;
  logic [10:0]    wid_q, hgt_q;
  logic           restart;
  logic [WW-1:0]  width;
  logic [HW-1:0]  height;
  edd_pkg::mode_t mode;

  logic          busy, q_push, q_pop, q_empty, pix_on;
  logic [7:0]    q_in, q_out;
  logic [QC-1:0] q_count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= 8'd127;
      meth_q <= 3'd0;
      wid_q  <= 11'd8;
      hgt_q  <= 11'd14;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        edd_pkg::REG_THRESHOLD: thr_q  <= cfg_wdata_i[7:0];
        edd_pkg::REG_METHOD:    meth_q <= cfg_wdata_i[2:0];
        edd_pkg::REG_WIDTH:     wid_q  <= cfg_wdata_i;
        edd_pkg::REG_HEIGHT:    hgt_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign restart = cfg_we_i && (cfg_idx_i == edd_pkg::REG_WIDTH
                              || cfg_idx_i == edd_pkg::REG_HEIGHT);

  always_comb begin
    if (wid_q == '0) width = WW'(1);
    else if (32'(wid_q) > 32'(MAX_WIDTH)) width = WW'(MAX_WIDTH);
    else width = WW'(wid_q);
    if (hgt_q == '0) height = HW'(1);
    else if (32'(hgt_q) > 32'(MAX_HEIGHT)) height = HW'(MAX_HEIGHT);
    else height = HW'(hgt_q);
  end

  assign mode.thr  = thr_q;
  assign mode.meth = meth_q;

  edd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .red_i       (s_axis_tdata[7:0]),
    .green_i     (s_axis_tdata[15:8]),
    .blue_i      (s_axis_tdata[23:16]),
    .busy_i      (busy),
    .q_count_i   (q_count),
    .push_o      (q_push),
    .luma_o      (q_in)
  );

  edd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_in),
    .pop_i       (q_pop),
    .pop_data_o  (q_out),
    .empty_o     (q_empty),
    .count_o     (q_count)
  );

  edd_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (mode),
    .width_i     (width),
    .height_i    (height),
    .restart_i   (restart),
    .q_empty_i   (q_empty),
    .q_luma_i    (q_out),
    .q_pop_o     (q_pop),
    .busy_o      (busy),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_on_o    (pix_on),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {7'd0, pix_on};

endmodule

`default_nettype wire

@@ sv/edd_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module edd_ram #(
  parameter int unsigned WIDTH = 18,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ sv/edd_fifo.sv @@
// ----------------------------------------------------------------------------
// Luma queue
// Short queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module edd_fifo (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire logic [7:0] push_data_i,
  input  wire logic       pop_i,
  output logic      [7:0] pop_data_o,
  output logic            empty_o,
  output logic      [$clog2(edd_pkg::FIFO_DEPTH+1)-1:0] count_o
);

  localparam int unsigned PW = $clog2(edd_pkg::FIFO_DEPTH);
  localparam int unsigned CW = $clog2(edd_pkg::FIFO_DEPTH+1);

  logic [7:0]    mem_q [edd_pkg::FIFO_DEPTH];
  logic [PW-1:0] wp_q, rp_q;
  logic [CW-1:0] cnt_q;

  assign pop_data_o = mem_q[rp_q];
  assign empty_o    = (cnt_q == '0);
  assign count_o    = cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + CW'(push_i) - CW'(pop_i);
    end
  end

  ap_no_underrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("pop from empty queue");
  ap_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |-> cnt_q < CW'(edd_pkg::FIFO_DEPTH)) else $error("push to full queue");
  ap_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count slip");

endmodule

`default_nettype wire

@@ sv/edd_front.sv @@
// ----------------------------------------------------------------------------
// Dither front end
// Accepts RGB words and turns them into luma for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module edd_front (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] red_i,
  input  wire logic [7:0] green_i,
  input  wire logic [7:0] blue_i,
  input  wire logic       busy_i,
  input  wire logic [$clog2(edd_pkg::FIFO_DEPTH+1)-1:0] q_count_i,
  output logic            push_o,
  output logic      [7:0] luma_o
);

  localparam int unsigned CW = $clog2(edd_pkg::FIFO_DEPTH+1);

  logic        s1_v_q;
  logic [14:0] sum_q;
  logic [30:0] prod;
  logic [CW:0] used;

  assign used       = {1'b0, q_count_i} + (CW+1)'(s1_v_q);
  assign in_ready_o = !busy_i && (used < (CW+1)'(edd_pkg::FIFO_DEPTH));
  assign prod       = 31'(sum_q) * 31'(edd_pkg::LUMA_RECIP);
  assign push_o     = s1_v_q;
  assign luma_o     = prod[edd_pkg::LUMA_SH +: 8];

  always_ff @(posedge clk_i) begin
    sum_q <= 15'(15'd30 * 15'(red_i)) + 15'(15'd59 * 15'(green_i))
           + 15'(15'd11 * 15'(blue_i));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= in_valid_i && in_ready_o;
    end
  end

endmodule

`default_nettype wire

@@ sv/edd_back.sv @@
// ----------------------------------------------------------------------------
// Dither back end
// Quantises each luma and, in a diffusion mode, spreads its error through the error store.
// ----------------------------------------------------------------------------
`default_nettype none

module edd_back #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire edd_pkg::mode_t        mode_i,
  input  wire logic [$clog2(MAX_WIDTH+1)-1:0]  width_i,
  input  wire logic [$clog2(MAX_HEIGHT+1)-1:0] height_i,
  input  wire logic                  restart_i,
  input  wire logic                  q_empty_i,
  input  wire logic [7:0]            q_luma_i,
  output logic                       q_pop_o,
  output logic                       busy_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic                       out_on_o,
  output logic                       out_last_o
);

  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned WW    = $clog2(MAX_WIDTH+1);
  localparam int unsigned RW    = $clog2(MAX_HEIGHT);
  localparam int unsigned HW    = $clog2(MAX_HEIGHT+1);
  localparam int unsigned AW    = CW + 2;
  localparam int unsigned DEPTH = 4 << CW;
  localparam int unsigned EW    = edd_pkg::ERR_W;
  localparam int unsigned OXW   = WW + 2;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_MUL, S_VAL, S_TAP} state_e;

  state_e        state_q;
  logic [AW-1:0] clr_q;
  logic [CW-1:0] col_q, cur_col_q;
  logic [RW-1:0] row_q, cur_row_q;
  logic [7:0]    lum_q;
  logic          diff_q, neg_q;
  logic [2:0]    k_q;
  logic [40:0]   prod_q;
  logic [8:0]    qerr_q;
  logic [3:0]    ti_q;
  logic          pw_q;
  logic [AW-1:0] pw_addr_q;
  logic [5:0]    pw_wt_q;
  logic          out_v_q, out_on_q, out_last_q;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [EW-1:0]        ram_wdata, ram_rdata;
  logic [CW-1:0]        eff_col;
  logic [RW-1:0]        eff_row;
  logic                 diff_now;
  logic [EW-1:0]        mag;
  logic [15:0]          quo, qs, v16;
  logic [7:0]           v8, wr8;
  logic                 on;
  logic                 out_free;
  logic                 spread;
  edd_pkg::tap_t        tap;
  logic [OXW-1:0]       ox;
  logic [HW:0]          oy;
  logic                 tap_ok;
  logic [15:0]          wprod;
  logic [WW-1:0]        col_inc;
  logic [HW-1:0]        row_inc;

  edd_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    if (WW'(col_q) >= width_i || HW'(row_q) >= height_i) begin
      eff_col = '0;
      eff_row = '0;
    end else begin
      eff_col = col_q;
      eff_row = row_q;
    end
  end

  assign diff_now = (mode_i.meth >= edd_pkg::METH_FIRST) && (mode_i.meth <= edd_pkg::METH_LAST);
  assign q_pop_o  = (state_q == S_IDLE) && !q_empty_i;
  assign busy_o   = (state_q == S_CLEAR);
  assign out_free = !out_v_q || out_ready_i;

  assign mag = ram_rdata[EW-1] ? EW'(-ram_rdata) : ram_rdata;
  assign quo = {1'b0, prod_q[edd_pkg::RECIP_SH +: 15]};
  assign qs  = neg_q ? 16'(-quo) : quo;
  assign v16 = 16'(lum_q) + qs;

  always_comb begin
    if (v16[15]) v8 = 8'd0;
    else if (v16 > 16'd255) v8 = 8'd255;
    else v8 = v16[7:0];
    on     = diff_q ? (v8 >= mode_i.thr) : (lum_q >= mode_i.thr);
    wr8    = on ? 8'd255 : 8'd0;
    spread = diff_q && (lum_q != wr8);
  end

  assign tap    = edd_pkg::KTAPS[k_q][ti_q];
  assign ox     = OXW'(cur_col_q) + OXW'(tap.dx) - OXW'(3);
  assign oy     = (HW+1)'(cur_row_q) + (HW+1)'(tap.dy);
  assign tap_ok = (ti_q < edd_pkg::TAP_CNT[k_q]) && !ox[OXW-1]
                && (ox < OXW'(width_i)) && (oy < (HW+1)'(height_i));
  assign wprod  = $signed({10'd0, pw_wt_q}) * $signed({{7{qerr_q[8]}}, qerr_q});

  assign col_inc = WW'(cur_col_q) + 1'b1;
  assign row_inc = HW'(cur_row_q) + 1'b1;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pw_addr_q;
    ram_wdata = ram_rdata + {{(EW-16){wprod[15]}}, wprod};
    ram_raddr = {eff_row[1:0], eff_col};
    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
      end
      S_VAL: begin
        ram_we    = out_free;
        ram_waddr = {cur_row_q[1:0], cur_col_q};
        ram_wdata = '0;
      end
      S_TAP: begin
        ram_we    = pw_q;
        ram_raddr = {oy[1:0], ox[CW-1:0]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        lum_q     <= q_luma_i;
        cur_col_q <= eff_col;
        cur_row_q <= eff_row;
        diff_q    <= diff_now;
        k_q       <= diff_now ? 3'(mode_i.meth - edd_pkg::METH_FIRST) : 3'd0;
      end
      S_MUL: begin
        neg_q  <= ram_rdata[EW-1];
        prod_q <= 41'(mag) * 41'(edd_pkg::RECIP[k_q]);
      end
      S_VAL: begin
        qerr_q <= 9'({1'b0, v8}) - 9'({1'b0, wr8});
      end
      S_TAP: begin
        pw_addr_q <= {oy[1:0], ox[CW-1:0]};
        pw_wt_q   <= tap.wt;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_q      <= '0;
      col_q      <= '0;
      row_q      <= '0;
      ti_q       <= '0;
      pw_q       <= 1'b0;
      out_v_q    <= 1'b0;
      out_on_q   <= 1'b0;
      out_last_q <= 1'b0;
    end else begin
      if (out_v_q && out_ready_i && !(state_q == S_VAL && !restart_i)) out_v_q <= 1'b0;
      if (restart_i) begin
        state_q <= S_CLEAR;
        clr_q   <= '0;
        col_q   <= '0;
        row_q   <= '0;
      end else begin
        unique case (state_q)
          S_CLEAR: begin
            clr_q <= clr_q + 1'b1;
            if (clr_q == AW'(DEPTH-1)) state_q <= S_IDLE;
          end
          S_IDLE: begin
            if (!q_empty_i) state_q <= S_MUL;
          end
          S_MUL: state_q <= S_VAL;
          S_VAL: begin
            if (out_free) begin
              out_v_q    <= 1'b1;
              out_on_q   <= on;
              out_last_q <= 1'b0;
              if (col_inc >= width_i) begin
                col_q <= '0;
                if (row_inc >= height_i) begin
                  row_q      <= '0;
                  out_last_q <= 1'b1;
                end else begin
                  row_q <= RW'(row_inc);
                end
              end else begin
                col_q <= CW'(col_inc);
              end
              ti_q    <= '0;
              pw_q    <= 1'b0;
              state_q <= spread ? S_TAP : S_IDLE;
            end
          end
          S_TAP: begin
            if (ti_q == edd_pkg::TAP_CNT[k_q]) begin
              pw_q    <= 1'b0;
              state_q <= S_IDLE;
            end else begin
              pw_q <= tap_ok;
              ti_q <= ti_q + 1'b1;
            end
          end
          default: state_q <= S_CLEAR;
        endcase
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign out_on_o    = out_on_q;
  assign out_last_o  = out_last_q;

  ap_no_pop_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |-> !q_pop_o) else $error("pop during clearing");
  ap_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !ram_we) else $error("store write while idle");
  ap_tap_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_TAP |-> ti_q <= edd_pkg::TAP_CNT[k_q]) else $error("tap index overrun");
  ap_pop_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o && !restart_i |=> state_q == S_MUL) else $error("pop without work");

endmodule

`default_nettype wire
